[hw/rtl/complex_matrix_multiply_core_macros.svh]
// assertion macros for the complex matrix multiply core
`ifndef COMPLEX_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define COMPLEX_MATRIX_MULTIPLY_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CMM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CMM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CMM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/cmm_pkg.sv]
// shared types and constants for the complex matrix multiply core
package cmm_pkg;

    localparam int OPC_W  = 2;
    localparam int IDX_W  = 3;
    localparam int CMP_W  = 16;
    localparam int PRD_W  = 32;
    localparam int ACC_W  = 36;
    localparam int QCNT_W = 2;

    localparam logic [OPC_W-1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [OPC_W-1:0] OP_COMPUTE    = 2'd2;

    localparam logic [QCNT_W-1:0] QCNT_RESET = 2'd3;

    typedef struct packed {
        logic signed [CMP_W-1:0] re;
        logic signed [CMP_W-1:0] im;
    } t_elem;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             first;
        logic             done;
        logic             last;
    } t_tag;

endpackage

[hw/rtl/cmm_mac.sv]
// shared complex multiply-accumulate unit with registered products and output
module cmm_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  cmm_pkg::t_tag                     i_tag,
    input  cmm_pkg::t_elem                    i_a,
    input  cmm_pkg::t_elem                    i_b,
    output logic                              o_busy,
    output logic                              o_vld,
    output cmm_pkg::t_tag                     o_tag,
    output logic signed [cmm_pkg::ACC_W-1:0]  o_re,
    output logic signed [cmm_pkg::ACC_W-1:0]  o_im
);
    import cmm_pkg::*;

    logic                    r_p_vld;
    t_tag                    r_p_tag;
    logic signed [PRD_W-1:0] r_p_rr;
    logic signed [PRD_W-1:0] r_p_ii;
    logic signed [PRD_W-1:0] r_p_ri;
    logic signed [PRD_W-1:0] r_p_ir;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic                    r_o_vld;
    t_tag                    r_o_tag;
    logic signed [ACC_W-1:0] r_o_re;
    logic signed [ACC_W-1:0] r_o_im;

    logic signed [PRD_W:0]   term_re;
    logic signed [PRD_W:0]   term_im;
    logic signed [ACC_W-1:0] base_re;
    logic signed [ACC_W-1:0] base_im;
    logic signed [ACC_W-1:0] n_acc_re;
    logic signed [ACC_W-1:0] n_acc_im;

    always_comb begin
        term_re  = (PRD_W+1)'(r_p_rr) - (PRD_W+1)'(r_p_ii);
        term_im  = (PRD_W+1)'(r_p_ri) + (PRD_W+1)'(r_p_ir);
        base_re  = r_p_tag.first ? '0 : r_acc_re;
        base_im  = r_p_tag.first ? '0 : r_acc_im;
        n_acc_re = base_re + ACC_W'(term_re);
        n_acc_im = base_im + ACC_W'(term_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_p_vld <= i_vld;
            r_o_vld <= r_p_vld && r_p_tag.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_p_tag <= i_tag;
            r_p_rr  <= i_a.re * i_b.re;
            r_p_ii  <= i_a.im * i_b.im;
            r_p_ri  <= i_a.re * i_b.im;
            r_p_ir  <= i_a.im * i_b.re;
        end
        if (r_p_vld) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
            if (r_p_tag.done) begin
                r_o_tag <= r_p_tag;
                r_o_re  <= n_acc_re;
                r_o_im  <= n_acc_im;
            end
        end
    end

    assign o_busy = r_p_vld;
    assign o_vld  = r_o_vld;
    assign o_tag  = r_o_tag;
    assign o_re   = r_o_re;
    assign o_im   = r_o_im;

endmodule

[hw/rtl/complex_matrix_multiply_core.sv]
// a load beat is stored at its accept edge, busy stays low, one load per cycle if idle
// a compute beat holds busy through run and drain, one multiply-accumulate per cycle
// through the single complex mac; operands pass the store read registers and the mac
// product registers; results follow in row-major order and cannot be stalled
// synchronous active-low reset clears control state and sets qubit_count to 3;
// the element stores are not cleared
`include "complex_matrix_multiply_core_macros.svh"

module complex_matrix_multiply_core #(
    parameter int MAX_QUBITS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cmm_pkg::QCNT_W-1:0]          i_cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic [cmm_pkg::OPC_W-1:0]           i_opcode,
    input  logic [cmm_pkg::IDX_W-1:0]           i_row,
    input  logic [cmm_pkg::IDX_W-1:0]           i_col,
    input  logic signed [cmm_pkg::CMP_W-1:0]    i_real_in,
    input  logic signed [cmm_pkg::CMP_W-1:0]    i_imag_in,
    output logic                                o_strobe,
    output logic [cmm_pkg::IDX_W-1:0]           o_out_row,
    output logic [cmm_pkg::IDX_W-1:0]           o_out_col,
    output logic signed [cmm_pkg::ACC_W-1:0]    o_real_out,
    output logic signed [cmm_pkg::ACC_W-1:0]    o_imag_out,
    output logic                                o_last
);
    import cmm_pkg::*;

    localparam int QW    = MAX_QUBITS;
    localparam int AW    = 2 * QW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [QCNT_W-1:0]   r_qcnt;
    logic [QW-1:0]       r_lim;
    logic [QW-1:0]       r_i, r_j, r_k;
    logic [QW-1:0]       n_i, n_j, n_k;
    logic                r_s1_vld;
    t_tag                r_s1_tag;
    t_elem               r_left_rd;
    t_elem               r_right_rd;
    t_elem               r_left_mem  [DEPTH];
    t_elem               r_right_mem [DEPTH];

    logic                accept;
    logic [QCNT_W-1:0]   qsat;
    logic [QW-1:0]       n_lim;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       left_raddr;
    logic [AW-1:0]       right_raddr;
    logic                k_end, j_end, i_end;
    t_tag                issue_tag;
    logic                mac_busy;
    t_tag                mac_tag;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign qsat        = (r_qcnt > QCNT_W'(MAX_QUBITS)) ? QCNT_W'(MAX_QUBITS) : r_qcnt;
    assign n_lim       = QW'((32'd1 << qsat) - 32'd1);
    assign waddr       = {i_row[QW-1:0], i_col[QW-1:0]};
    assign left_raddr  = {r_i, r_k};
    assign right_raddr = {r_k, r_j};
    assign k_end       = (r_k == r_lim);
    assign j_end       = (r_j == r_lim);
    assign i_end       = (r_i == r_lim);

    always_comb begin
        issue_tag.row   = IDX_W'(r_i);
        issue_tag.col   = IDX_W'(r_j);
        issue_tag.first = (r_k == '0);
        issue_tag.done  = k_end;
        issue_tag.last  = i_end && j_end;
    end

    // loop counters and sequencer
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_opcode == OP_COMPUTE) begin
                    n_state = ST_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            ST_RUN: begin
                n_k = k_end ? '0 : r_k + 1'b1;
                if (k_end) begin
                    n_j = j_end ? '0 : r_j + 1'b1;
                    if (j_end) begin
                        n_i = r_i + 1'b1;
                        if (i_end) begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_s1_vld && !mac_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_qcnt   <= QCNT_RESET;
            r_s1_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= (r_state == ST_RUN);
            if (i_cfg_we) begin
                r_qcnt <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_s1_tag <= issue_tag;
        if (accept && i_opcode == OP_COMPUTE) begin
            r_lim <= n_lim;
        end
    end

    // element stores
    always_ff @(posedge i_clk) begin
        if (accept && i_opcode == OP_LOAD_LEFT) begin
            r_left_mem[waddr] <= '{re: i_real_in, im: i_imag_in};
        end
        r_left_rd <= r_left_mem[left_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_opcode == OP_LOAD_RIGHT) begin
            r_right_mem[waddr] <= '{re: i_real_in, im: i_imag_in};
        end
        r_right_rd <= r_right_mem[right_raddr];
    end

    cmm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s1_vld),
        .i_tag   (r_s1_tag),
        .i_a     (r_left_rd),
        .i_b     (r_right_rd),
        .o_busy  (mac_busy),
        .o_vld   (o_strobe),
        .o_tag   (mac_tag),
        .o_re    (o_real_out),
        .o_im    (o_imag_out)
    );

    assign o_out_row = mac_tag.row;
    assign o_out_col = mac_tag.col;
    assign o_last    = o_strobe && mac_tag.last;

    `CMM_ASSERT_SAME(a_strobe_in_run, i_clk, i_rst_n, o_strobe, $past(busy))
    `CMM_ASSERT_NEXT(a_compute_busy, i_clk, i_rst_n, accept && i_opcode == OP_COMPUTE, busy)
    `CMM_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, o_strobe && o_last, !o_strobe)
    `CMM_ASSERT_SAME(a_drain_empty, i_clk, i_rst_n, r_state == ST_IDLE, !r_s1_vld && !mac_busy)

endmodule
